// ----- rtl/markup_fragment_tokenizer_macros.svh -----
// assertion macros for the markup fragment tokenizer
`ifndef MARKUP_FRAGMENT_TOKENIZER_MACROS_SVH
`define MARKUP_FRAGMENT_TOKENIZER_MACROS_SVH

// property checked only outside reset
`define MFT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// property checked at every edge, reset included
`define MFT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- rtl/mft_pkg.sv -----
// types, constants and codes shared by the markup fragment tokenizer
`default_nettype none

package mft_pkg;

    localparam int LEVEL_BITS  = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [7:0]            char_t;
    typedef logic [2:0]            kind_t;
    typedef logic [7:0]            frag_level_t;
    typedef logic [LEVEL_BITS-1:0] level_t;

    localparam level_t LEVEL_MAX = {LEVEL_BITS{1'b1}};

    localparam char_t CH_LT    = 8'h3C;
    localparam char_t CH_GT    = 8'h3E;
    localparam char_t CH_EQ    = 8'h3D;
    localparam char_t CH_QUOTE = 8'h22;
    localparam char_t CH_SLASH = 8'h2F;
    localparam char_t CH_SPACE = 8'h20;

    localparam kind_t KIND_TEXT       = 3'd0;
    localparam kind_t KIND_TAG        = 3'd1;
    localparam kind_t KIND_ATTR_NAME  = 3'd2;
    localparam kind_t KIND_ATTR_VALUE = 3'd3;
    localparam kind_t KIND_CLOSE      = 3'd4;

    typedef enum logic [3:0] {
        MODE_TEXT       = 4'b0001,
        MODE_TAG        = 4'b0010,
        MODE_ATTR_NAME  = 4'b0100,
        MODE_ATTR_VALUE = 4'b1000
    } mode_t;

    typedef struct packed {
        char_t char_code;
        logic  start_of_content;
    } in_item_t;

    typedef struct packed {
        char_t       out_char;
        logic        char_present;
        kind_t       fragment_kind;
        frag_level_t fragment_level;
        logic        fragment_end;
    } out_item_t;

    // one classified byte handed from front to back
    typedef struct packed {
        char_t ch;
        kind_t kind;
        logic  start;
        logic  do_finish;
        logic  do_append;
    } op_t;

endpackage

`default_nettype wire

// ----- rtl/mft_front.sv -----
// front end: tracks the parse mode and classifies each byte into an operation
`default_nettype none

module mft_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mft_pkg::in_item_t s_item,
    output logic                   op_valid,
    input  wire logic              op_ready,
    output mft_pkg::op_t           op
);

    mft_pkg::mode_t mode_reg, mode_next, mode_eff;
    logic           esc_reg, esc_next, esc_eff;
    logic           push;
    mft_pkg::char_t c;

    assign c        = s_item.char_code;
    assign s_ready  = op_ready;
    assign op_valid = s_valid;
    assign push     = s_valid && op_ready;

    always_comb begin
        mode_eff = s_item.start_of_content ? mft_pkg::MODE_TEXT : mode_reg;
        esc_eff  = s_item.start_of_content ? 1'b0 : esc_reg;
        mode_next    = mode_eff;
        esc_next     = esc_eff;
        op.ch        = c;
        op.kind      = mft_pkg::KIND_TEXT;
        op.start     = s_item.start_of_content;
        op.do_finish = 1'b0;
        op.do_append = 1'b0;
        case (mode_eff)
            mft_pkg::MODE_TEXT: begin
                if (c == mft_pkg::CH_LT) begin
                    op.do_finish = 1'b1;
                    mode_next    = mft_pkg::MODE_TAG;
                end else begin
                    op.do_append = 1'b1;
                    op.kind      = mft_pkg::KIND_TEXT;
                end
            end
            mft_pkg::MODE_TAG: begin
                if (c == mft_pkg::CH_GT) begin
                    op.do_finish = 1'b1;
                    mode_next    = mft_pkg::MODE_TEXT;
                end else if (c == mft_pkg::CH_SPACE) begin
                    op.do_finish = 1'b1;
                    mode_next    = mft_pkg::MODE_ATTR_NAME;
                end else begin
                    op.do_append = 1'b1;
                    op.kind      = mft_pkg::KIND_TAG;
                end
            end
            mft_pkg::MODE_ATTR_NAME: begin
                if (c == mft_pkg::CH_EQ) begin
                    op.do_finish = 1'b1;
                    mode_next    = mft_pkg::MODE_ATTR_VALUE;
                    esc_next     = 1'b1;
                end else if (c == mft_pkg::CH_GT) begin
                    op.do_finish = 1'b1;
                    mode_next    = mft_pkg::MODE_TEXT;
                end else if (c == mft_pkg::CH_SLASH) begin
                    // slash closes the name and opens a new tag fragment
                    op.do_finish = 1'b1;
                    op.do_append = 1'b1;
                    op.kind      = mft_pkg::KIND_TAG;
                    mode_next    = mft_pkg::MODE_TAG;
                end else begin
                    op.do_append = 1'b1;
                    op.kind      = mft_pkg::KIND_ATTR_NAME;
                end
            end
            mft_pkg::MODE_ATTR_VALUE: begin
                if (c == mft_pkg::CH_QUOTE && !esc_eff) begin
                    op.do_finish = 1'b1;
                    mode_next    = mft_pkg::MODE_TAG;
                end else begin
                    op.do_append = 1'b1;
                    op.kind      = mft_pkg::KIND_ATTR_VALUE;
                end
                esc_next = 1'b0;
            end
            default: begin
                mode_next = mft_pkg::MODE_TEXT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= mft_pkg::MODE_TEXT;
            esc_reg  <= 1'b0;
        end else if (push) begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mft_queue.sv -----
// short operation queue between front and back
`default_nettype none

module mft_queue (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         wr_valid,
    output logic              wr_ready,
    input  wire mft_pkg::op_t wr_op,
    output logic              rd_valid,
    input  wire logic         rd_ready,
    output mft_pkg::op_t      rd_op
);

    localparam int PTR_W = (mft_pkg::QUEUE_DEPTH > 1) ? $clog2(mft_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(mft_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(mft_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(mft_pkg::QUEUE_DEPTH);

    mft_pkg::op_t     slot_reg [mft_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_op    = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mft_back.sv -----
// back end: fragment state, nesting level and registered result item
`default_nettype none

module mft_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               op_valid,
    output logic                    op_ready,
    input  wire mft_pkg::op_t       op,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output mft_pkg::out_item_t      m_item
);

    mft_pkg::level_t    level_reg, level_next;
    mft_pkg::char_t     held_reg, held_next;
    logic               held_valid_reg, held_valid_next;
    logic               open_reg, open_next;
    mft_pkg::kind_t     kind_reg, kind_next;
    logic               slash_reg, slash_next;
    logic               m_valid_reg, m_valid_next;
    mft_pkg::out_item_t m_item_reg, m_item_next;
    mft_pkg::out_item_t res;
    logic               emit;
    logic               pop;

    assign op_ready = !m_valid_reg || m_ready;
    assign pop      = op_valid && op_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    always_comb begin
        level_next      = op.start ? '0 : level_reg;
        held_next       = op.start ? '0 : held_reg;
        held_valid_next = op.start ? 1'b0 : held_valid_reg;
        open_next       = op.start ? 1'b0 : open_reg;
        kind_next       = op.start ? mft_pkg::KIND_TEXT : kind_reg;
        slash_next      = op.start ? 1'b0 : slash_reg;
        emit            = 1'b0;
        res             = '0;

        if (op.do_finish && open_next) begin
            if (slash_next) begin
                kind_next = mft_pkg::KIND_CLOSE;
                if (level_next != '0) begin
                    level_next = level_next - mft_pkg::level_t'(1);
                end
            end
            emit               = 1'b1;
            res.out_char       = held_valid_next ? held_next : '0;
            res.char_present   = held_valid_next;
            res.fragment_kind  = kind_next;
            res.fragment_level = mft_pkg::frag_level_t'(level_next);
            res.fragment_end   = 1'b1;
            if (kind_next == mft_pkg::KIND_TAG && level_next != mft_pkg::LEVEL_MAX) begin
                level_next = level_next + mft_pkg::level_t'(1);
            end
            open_next       = 1'b0;
            held_valid_next = 1'b0;
            held_next       = '0;
            slash_next      = 1'b0;
        end

        if (op.do_append) begin
            if (!open_next) begin
                open_next = 1'b1;
                kind_next = op.kind;
                if (op.kind != mft_pkg::KIND_TEXT && op.ch == mft_pkg::CH_SLASH) begin
                    slash_next      = 1'b1;
                    held_next       = op.ch;
                    held_valid_next = 1'b1;
                end else if (op.kind == mft_pkg::KIND_ATTR_VALUE &&
                             op.ch == mft_pkg::CH_QUOTE) begin
                    held_valid_next = 1'b0;
                end else begin
                    held_next       = op.ch;
                    held_valid_next = 1'b1;
                end
            end else begin
                if (slash_next) begin
                    // second byte turns the fragment into a close tag
                    slash_next = 1'b0;
                    kind_next  = mft_pkg::KIND_CLOSE;
                    if (level_next != '0) begin
                        level_next = level_next - mft_pkg::level_t'(1);
                    end
                end else if (held_valid_next) begin
                    emit               = 1'b1;
                    res.out_char       = held_next;
                    res.char_present   = 1'b1;
                    res.fragment_kind  = kind_next;
                    res.fragment_level = mft_pkg::frag_level_t'(level_next);
                    res.fragment_end   = 1'b0;
                end
                held_next       = op.ch;
                held_valid_next = 1'b1;
            end
        end
    end

    always_comb begin
        if (pop) begin
            m_valid_next = emit;
            m_item_next  = res;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
            m_item_next  = m_item_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg      <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            open_reg       <= 1'b0;
            kind_reg       <= mft_pkg::KIND_TEXT;
            slash_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (pop) begin
                level_reg      <= level_next;
                held_reg       <= held_next;
                held_valid_reg <= held_valid_next;
                open_reg       <= open_next;
                kind_reg       <= kind_next;
                slash_reg      <= slash_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

endmodule

`default_nettype wire

// ----- rtl/markup_fragment_tokenizer.sv -----
// top level of the markup fragment tokenizer
// Usage:
// s_ channel takes one markup byte per item; start_of_content clears all
// parse state before that byte is used. m_ channel gives zero or one result
// item per input item: a fragment character tagged with its kind and nesting
// level, with fragment_end on the last item of each fragment.
// Each character is held back until the next byte, so a fragment's last
// character leaves when its delimiter arrives.
// Throughput: while m_ready is high, one item per clock in both directions;
// the back end updates fragment state for one queued byte per cycle.
// Path: an accepted byte is written into a queue slot; the back end then
// takes it from the queue and writes any result into the output register.
// A two-entry queue separates the mode classifier from the fragment back end;
// when m_ready is low while an item waits, the output register holds it, the
// back end stops and s_ready falls once the queue is full.
// Reset (aresetn low, synchronous) empties the queue, drops any held item and
// returns to text mode at level zero; s_ready is high in the next cycle.
`default_nettype none

module markup_fragment_tokenizer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire mft_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output mft_pkg::out_item_t      m_item
);

    mft_pkg::op_t front_op;
    mft_pkg::op_t back_op;
    logic         front_valid, front_ready;
    logic         back_valid, back_ready;

    mft_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .op_valid (front_valid),
        .op_ready (front_ready),
        .op       (front_op)
    );

    mft_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_op    (front_op),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_op    (back_op)
    );

    mft_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (back_valid),
        .op_ready (back_ready),
        .op       (back_op),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

`default_nettype wire

// ----- rtl/mft_checker.sv -----
// port-level checks for the markup fragment tokenizer, bound to the top level
`default_nettype none

`include "markup_fragment_tokenizer_macros.svh"

module mft_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire mft_pkg::in_item_t  s_item,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire mft_pkg::out_item_t m_item
);

    `MFT_ASSERT_ALWAYS(a_reset_clears_out, aclk, (!aresetn |=> !m_valid), "item after reset")

    `MFT_ASSERT(a_out_held, aclk, aresetn, (m_valid && !m_ready |=> m_valid && $stable(m_item)), "stalled item changed")

    `MFT_ASSERT(a_empty_marker, aclk, aresetn, (m_valid && !m_item.char_present |-> m_item.out_char == 8'h00 && m_item.fragment_end && m_item.fragment_kind == mft_pkg::KIND_ATTR_VALUE), "bad empty end marker")

    `MFT_ASSERT(a_no_text_early, aclk, aresetn, ($past(!aresetn) |-> !m_valid), "item too soon after reset")

endmodule

bind markup_fragment_tokenizer mft_checker u_mft_checker (.*);

`default_nettype wire
